// ----- rtl/gjd_pkg.sv -----
// Package for the Gregorian to Jalali date converter: payload structs,
// calendar constants and month tables. No dependencies.
`default_nettype none

package gjd_pkg;

	typedef struct packed {
		logic [15:0] greg_year;
		logic [7:0]  greg_month;
		logic [7:0]  greg_day;
	} greg_date_t;

	typedef struct packed {
		logic [10:0] jal_year;
		logic [3:0]  jal_month;
		logic [4:0]  jal_day;
	} jal_date_t;

	localparam logic [15:0] YEAR_MIN     = 16'd2000;
	localparam logic [15:0] YEAR_MAX     = 16'd2100;
	localparam logic [15:0] YEAR_DEFAULT = 16'd2012;
	localparam logic [15:0] YEAR_BASE    = 16'd1600;

	localparam logic [17:0] EPOCH_OFFSET = 18'd79;
	localparam logic [17:0] CYC33_DAYS   = 18'd12053;
	localparam logic [13:0] CYC4_DAYS    = 14'd1461;
	localparam logic [10:0] YEAR_DAYS    = 11'd365;
	localparam logic [10:0] LEAP_DAYS    = 11'd366;
	localparam logic [10:0] JAL_YEAR_BASE = 11'd979;

	// Days before each Gregorian month in a common year
	localparam logic [8:0] CUM_DAYS [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	// Day of year on which each Jalali month starts, zero based
	localparam logic [8:0] JMON_START [12] = '{
		9'd0, 9'd31, 9'd62, 9'd93, 9'd124, 9'd155,
		9'd186, 9'd216, 9'd246, 9'd276, 9'd306, 9'd336
	};

endpackage

`default_nettype wire

// ----- rtl/gregorian_to_jalali_date.sv -----
// Gregorian to Jalali date converter, five-stage pipeline.
// Depends on gjd_pkg for the payload structs and calendar tables.
`default_nettype none

// Usage
//   Input channel: drive greg and raise start; the item is taken at the
//   rising edge where start is high and busy is low. busy is high only while
//   arst_n is low, so outside reset a new date may be offered in every cycle.
//   Result channel: done is high for exactly one cycle with the converted
//   date on jal; the receiver must take it in that cycle, it cannot stall.
//   Path: an item taken at one edge goes through the registers s1 to s5
//   in turn and then shows on jal. Throughput: one item per cycle.
//   Stages:
//     s1 clamp fields, count days since 1600 less the epoch offset
//     s2 split off 33-year cycles (parallel compares)
//     s3 split off 4-year cycles
//     s4 split off single years inside the 4-year cycle
//     s5 find the Jalali month and day from the month start table
//   Reset: arst_n clears every stage's valid bit at once; items in flight
//   are dropped and no result appears until a new item has gone through.
//   Out-of-range years, months and days are replaced by defaults before
//   the count; days past a month's end roll into the following month.
module gregorian_to_jalali_date (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  gjd_pkg::greg_date_t greg,
	output logic                done,
	output gjd_pkg::jal_date_t  jal
);
	import gjd_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [17:0] days_s1;
	logic [3:0]  cyc_s2;
	logic [13:0] rem_s2;
	logic [10:0] jy_s3;
	logic [10:0] rem_s3;
	logic [10:0] jy_s4;
	logic [8:0]  doy_s4;
	jal_date_t   res_s5;

	logic        accept;
	logic [15:0] yr;
	logic [3:0]  mo;
	logic [4:0]  dy;
	logic [8:0]  ys;
	logic        leap;
	logic [17:0] days_d;
	logic [3:0]  cyc_d;
	logic [13:0] rem2_d;
	logic [3:0]  q4_d;
	logic [10:0] rem3_d;
	logic [10:0] jy3_d;
	logic [10:0] t4;
	logic [1:0]  q1_d;
	logic [8:0]  rem4_d;
	logic [10:0] jy4_d;
	logic [8:0]  doy_d;
	logic [3:0]  m_d;
	jal_date_t   res_d;

	// Refuse items only while reset is held; no stage ever holds
	assign busy   = !arst_n;
	assign accept = start && !busy;

	// Stage 1: clamp the fields and count days since 1 January 1600, less the epoch offset.
	// ys spans 400..500, so the century and 400-year terms step at 401.
	always_comb begin
		yr = (greg.greg_year < YEAR_MIN || greg.greg_year > YEAR_MAX) ?
			YEAR_DEFAULT : greg.greg_year;
		mo = (greg.greg_month == 8'd0 || greg.greg_month > 8'd12) ?
			4'd1 : greg.greg_month[3:0];
		dy = (greg.greg_day == 8'd0 || greg.greg_day > 8'd31) ?
			5'd1 : greg.greg_day[4:0];
		ys = 9'(yr - YEAR_BASE);
		// Within this range a multiple of four is a leap year except ys = 500
		leap = (ys[1:0] == 2'b00) && (ys != 9'd500);
		days_d = 18'(ys) * 18'd365
			+ 18'(({1'b0, ys} + 10'd3) >> 2)
			- (({1'b0, ys} + 10'd99 >= 10'd500) ? 18'd5 : 18'd4)
			+ (({1'b0, ys} + 10'd399 >= 10'd800) ? 18'd2 : 18'd1)
			+ 18'(CUM_DAYS[4'(mo - 4'd1)])
			+ 18'(leap && (mo > 4'd2))
			+ 18'(dy) - 18'd1
			- EPOCH_OFFSET;
	end

	// Stage 2: the count lies in 12..15 whole 33-year cycles
	always_comb begin
		cyc_d = 4'd12
			+ 4'(days_s1 >= 18'(13 * CYC33_DAYS))
			+ 4'(days_s1 >= 18'(14 * CYC33_DAYS))
			+ 4'(days_s1 >= 18'(15 * CYC33_DAYS));
		rem2_d = 14'(days_s1 - 18'(cyc_d) * CYC33_DAYS);
	end

	// Stage 3: 0..8 whole 4-year cycles inside the 33-year cycle
	always_comb begin
		q4_d = 4'd0;
		for (int k = 1; k <= 8; k++) begin
			q4_d = q4_d + 4'(rem_s2 >= 14'(k * CYC4_DAYS));
		end
		rem3_d = 11'(rem_s2 - 14'(q4_d) * CYC4_DAYS);
		jy3_d  = JAL_YEAR_BASE + 11'(cyc_s2) * 11'd33 + 11'({q4_d, 2'b00});
	end

	// Stage 4: the first year of a 4-year cycle has 366 days, the rest 365
	always_comb begin
		t4   = rem_s3 - 11'd1;
		q1_d = 2'(t4 >= YEAR_DAYS) + 2'(t4 >= 11'(2 * YEAR_DAYS))
			+ 2'(t4 >= 11'(3 * YEAR_DAYS));
		rem4_d = 9'(t4 - 11'(q1_d) * YEAR_DAYS);
		if (rem_s3 >= LEAP_DAYS) begin
			jy4_d = jy_s3 + 11'(q1_d);
			doy_d = rem4_d;
		end else begin
			jy4_d = jy_s3;
			doy_d = 9'(rem_s3);
		end
	end

	// Stage 5: leftover days past the eleventh month all fall in Esfand
	always_comb begin
		m_d = 4'd0;
		for (int k = 1; k < 12; k++) begin
			m_d = m_d + 4'(doy_s4 >= JMON_START[k]);
		end
		res_d.jal_year  = jy_s4;
		res_d.jal_month = m_d + 4'd1;
		res_d.jal_day   = 5'(doy_s4 - JMON_START[m_d] + 9'd1);
	end

	// Valid bits: cleared by reset, advance every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Payload registers: no reset, qualified by the valid bits
	always_ff @(posedge clk) begin
		days_s1 <= days_d;
		cyc_s2  <= cyc_d;
		rem_s2  <= rem2_d;
		jy_s3   <= jy3_d;
		rem_s3  <= rem3_d;
		jy_s4   <= jy4_d;
		doy_s4  <= doy_d;
		res_s5  <= res_d;
	end

	assign done = v_s5;
	assign jal  = res_s5;

	// Every accepted item leaves through s1 to s5 on done, and nothing else does
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##5 done)
		else $error("accepted date did not come out after five cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 5))
		else $error("result strobe without a matching accepted date");

	a_month_day: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (jal.jal_month >= 4'd1 && jal.jal_month <= 4'd12
			&& jal.jal_day >= 5'd1 && jal.jal_day <= 5'd31))
		else $error("Jalali month or day out of range");

	a_year: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (jal.jal_year >= 11'd1378 && jal.jal_year <= 11'd1479))
		else $error("Jalali year out of range");

endmodule

`default_nettype wire
